FILE: design/ohs_pkg.sv
// Package: shared types and constants for the open addressing hash set.
package ohs_pkg;

  localparam int TableDepth = 1024;
  localparam int KeyBits    = 32;
  localparam int SlotBits   = $clog2(TableDepth);
  localparam int SizeBits   = SlotBits + 1;
  localparam int CfgBits    = 31;
  localparam int ModBits    = 31;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;
  localparam logic [1:0] OP_SPARE  = 2'd3; // decoded as lookup

  localparam logic [1:0] CFG_MULT  = 2'd0;
  localparam logic [1:0] CFG_PRIME = 2'd1;
  localparam logic [1:0] CFG_SIZE  = 2'd2;

  localparam logic [1:0] ST_EMPTY = 2'd0;
  localparam logic [1:0] ST_LIVE  = 2'd1;
  localparam logic [1:0] ST_TOMB  = 2'd2;

  // reduction operand select
  localparam logic [1:0] MOD_KEY  = 2'd0; // |key| mod p
  localparam logic [1:0] MOD_PROD = 2'd1; // m*r mod p
  localparam logic [1:0] MOD_SIZE = 2'd2; // r mod size

  typedef struct packed {
    logic [1:0]          operation;
    logic signed [31:0]  key;
  } req_t;

  typedef struct packed {
    logic        found;
    logic        table_full;
    logic [10:0] live_entries;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture request, start first reduction
    logic mod_start;  // start a reduction of mod_sel operand
    logic [1:0] mod_sel; // MOD_KEY, MOD_PROD or MOD_SIZE
    logic set_home;   // home slot from last remainder
    logic rd;         // issue read at probe position
    logic advance;    // step probe position
    logic commit;     // apply insert/delete and form response
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic mod_done;
    logic slot_empty;
    logic slot_hit;
    logic walk_end;   // visited all slots
  } sts_t;

endpackage

FILE: design/ohs_mod.sv
// Module: restoring modulo unit, one quotient bit per cycle.
module ohs_mod
  import ohs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [40:0]        dividend,
  input  logic [ModBits-1:0] divisor,
  output logic               done,
  output logic [ModBits-1:0] remainder
);
  logic [40:0]        num;
  logic [ModBits:0]   rem;
  logic [5:0]         cnt;
  logic               busy;
  logic [ModBits+1:0] trial;

  assign trial = {rem, num[40]} - {2'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        num  <= dividend;
        rem  <= '0;
        cnt  <= 6'd41;
      end else if (busy) begin
        num <= {num[39:0], 1'b0};
        if (!trial[ModBits+1]) rem <= trial[ModBits:0];
        else rem <= {rem[ModBits-1:0], num[40]};
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign remainder = rem[ModBits-1:0];
endmodule

FILE: design/ohs_datapath.sv
// Module: hash datapath, slot store, probe walk and counters.
module ohs_datapath
  import ohs_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic [9:0]   mult,
  input  logic [30:0]  prime,
  input  logic [10:0]  tsize,
  input  req_t         req,
  input  cmd_t         cmd,
  output sts_t         sts,
  output rsp_t         rsp
);
  logic [KeyBits-1:0]  slot_keys [TableDepth];
  logic [1:0]          slot_status [TableDepth];
  logic [SlotBits:0]   clr_cnt;

  logic [1:0]          op;
  logic [KeyBits-1:0]  key;
  logic                neg;
  logic [SizeBits-1:0] m;
  logic [ModBits-1:0]  p;
  logic [SlotBits-1:0] pos;
  logic [SizeBits-1:0] steps;
  logic [KeyBits-1:0]  rd_key;
  logic [1:0]          rd_st;
  logic [10:0]         live_count, tomb_count;
  logic [40:0]         dividend;
  logic                mod_done;
  logic [ModBits-1:0]  rem;
  logic [SlotBits-1:0] home;
  logic [SlotBits-1:0] pos_inc;
  logic [KeyBits-1:0]  mag;
  logic [SizeBits-1:0] sz_eff;
  logic                hit, empt;
  logic                found, full;

  assign sz_eff = (tsize < 11'd2) ? 11'd2 :
                  (tsize > 11'(TableDepth)) ? 11'(TableDepth) : tsize;
  assign mag = req.key[KeyBits-1] ? (~req.key + 1'b1) : req.key;

  // product fits 41 bits: 10-bit multiplier by 31-bit remainder
  always_comb begin
    case (cmd.mod_sel)
      MOD_KEY:  dividend = {9'd0, key};
      MOD_PROD: dividend = {31'd0, mult} * {10'd0, rem};
      default:  dividend = {10'd0, rem};
    endcase
  end

  // divisor: size for the final reduction, otherwise the prime
  ohs_mod u_mod (
    .clk(clk), .rst(rst), .start(cmd.mod_start | cmd.load),
    .dividend(cmd.load ? {9'd0, mag} : dividend),
    .divisor(cmd.mod_sel == MOD_SIZE ? {20'd0, m} :
             (cmd.load ? ((prime == '0) ? 31'd1 : prime) : p)),
    .done(mod_done), .remainder(rem)
  );

  // home: mirror for negative keys
  assign home = (neg && rem[SlotBits:0] != '0) ?
                SlotBits'(m - rem[SizeBits-1:0]) : rem[SlotBits-1:0];
  assign pos_inc = (SizeBits'(pos) + 1'b1 == m) ? '0 : pos + 1'b1;
  assign empt = (rd_st == ST_EMPTY) | ~clr_cnt[SlotBits];
  assign hit  = (rd_st == ST_LIVE) & (rd_key == key);

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_key <= slot_keys[pos];
      rd_st  <= slot_status[pos];
    end
    if (cmd.commit && op == OP_INSERT && !hit && empt)
      slot_keys[pos] <= key;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt    <= '0;
      live_count <= '0;
      tomb_count <= '0;
    end else begin
      if (!clr_cnt[SlotBits]) begin
        slot_status[clr_cnt[SlotBits-1:0]] <= ST_EMPTY;
        clr_cnt <= clr_cnt + 1'b1;
      end else if (cmd.commit) begin
        if (op == OP_INSERT && !hit && empt && steps != m &&
            (live_count + tomb_count) < 11'(m >> 1)) begin
          slot_status[pos] <= ST_LIVE;
          live_count <= live_count + 1'b1;
        end else if (op == OP_DELETE && hit) begin
          slot_status[pos] <= ST_TOMB;
          live_count <= live_count - 1'b1;
          tomb_count <= tomb_count + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op  <= req.operation;
      key <= req.key;
      neg <= req.key[KeyBits-1];
      m   <= sz_eff;
      p   <= (prime == '0) ? 31'd1 : prime;
    end
    if (cmd.set_home) begin
      pos   <= home;
      steps <= '0;
    end else if (cmd.advance) begin
      pos   <= pos_inc;
      steps <= steps + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      found <= (steps != m) & hit;
      full  <= (op == OP_INSERT) & ~((steps != m) & hit) &
        ((steps == m) | ~empt | ((live_count + tomb_count) >= 11'(m >> 1)));
    end
  end
  assign rsp = '{found: found, table_full: full, live_entries: live_count};

  assign sts.mod_done   = mod_done;
  assign sts.slot_empty = empt;
  assign sts.slot_hit   = hit;
  assign sts.walk_end   = (steps == m);
endmodule

FILE: design/ohs_ctrl.sv
// Module: controller state machine sequencing hash and probe walk.
module ohs_ctrl
  import ohs_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  logic cleared,
  input  sts_t sts,
  output cmd_t cmd
);
  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001, S_M0 = 8'b00000010, S_M1 = 8'b00000100,
    S_M2 = 8'b00001000, S_RD = 8'b00010000, S_CHK = 8'b00100000,
    S_CMT = 8'b01000000, S_OUT = 8'b10000000
  } state_t;
  state_t state, state_next;

  assign in_ready  = (state == S_IDLE) & cleared;
  assign out_valid = (state == S_OUT);

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_IDLE: if (in_valid && cleared) begin
        cmd.load = 1'b1;
        state_next = S_M0;
      end
      S_M0: if (sts.mod_done) begin
        cmd.mod_start = 1'b1; cmd.mod_sel = MOD_PROD; state_next = S_M1;
      end
      S_M1: begin
        cmd.mod_sel = MOD_PROD;
        if (sts.mod_done) begin
          cmd.mod_start = 1'b1; cmd.mod_sel = MOD_SIZE; state_next = S_M2;
        end
      end
      S_M2: begin
        cmd.mod_sel = MOD_SIZE;
        if (sts.mod_done) begin
          cmd.set_home = 1'b1; state_next = S_RD;
        end
      end
      S_RD: begin
        cmd.rd = 1'b1; state_next = S_CHK;
      end
      S_CHK: begin
        if (sts.walk_end || sts.slot_empty || sts.slot_hit) begin
          state_next = S_CMT;
        end else begin
          cmd.advance = 1'b1;
          state_next = S_RD;
        end
      end
      S_CMT: begin
        cmd.commit = 1'b1; state_next = S_OUT;
      end
      S_OUT: if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end
endmodule

FILE: design/open_addressing_hash_set_core.sv
// Module: top level of the linear probing hash set with tombstones.
// Sequence: hashing (three restoring reductions of 41 quotient bits each in one
// shared modulo unit), then a read and a check per probed slot, then a commit,
// before the response is offered.
// Requests: one at a time; the next is taken in the cycle after the response goes.
// Reset: synchronous; a clearing pass marks every slot empty,
// during which no request is accepted. Registers reset to 31, 1031, 1024.
module open_addressing_hash_set_core
  import ohs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  req_t        in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output rsp_t        out_data
);
  logic [9:0]  mult;
  logic [30:0] prime;
  logic [10:0] tsize;
  cmd_t cmd;
  sts_t sts;
  logic cleared;
  logic [SlotBits:0] clr;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mult  <= 10'd31;
      prime <= 31'd1031;
      tsize <= 11'd1024;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MULT:  mult  <= cfg_data[9:0];
        CFG_PRIME: prime <= cfg_data;
        CFG_SIZE:  tsize <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // mirrors the datapath clearing sweep
  always_ff @(posedge clk) begin
    if (rst) clr <= '0;
    else if (!clr[SlotBits]) clr <= clr + 1'b1;
  end
  assign cleared = clr[SlotBits];

  ohs_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .cleared(cleared),
    .sts(sts), .cmd(cmd)
  );

  ohs_datapath u_dp (
    .clk(clk), .rst(rst), .mult(mult), .prime(prime), .tsize(tsize),
    .req(in_data), .cmd(cmd), .sts(sts), .rsp(out_data)
  );
endmodule

FILE: test/open_addressing_hash_set_core_chk.sv
// Checker for the hash set core: watches both channels and scores every response.
module open_addressing_hash_set_core_chk
  import ohs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  req_t        in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  rsp_t        out_data,
  output int          fails,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [9:0]  mult;
  logic [30:0] prime;
  logic [10:0] size;
  logic [31:0] slot_key [TableDepth];
  logic [1:0]  slot_state [TableDepth];
  int unsigned live_cnt;
  int unsigned tomb_cnt;
  rsp_t        rsp_due [$];

  assign pending = rsp_due.size();

  function automatic int unsigned home_of(logic [31:0] k, int unsigned m);
    longint unsigned p, mag, r, h;
    logic [31:0] neg_k;
    p = (prime == 0) ? 1 : longint'(prime);
    neg_k = ~k + 32'd1;
    mag = k[31] ? longint'(neg_k) : longint'(k);
    r = (longint'(mult) * (mag % p)) % p;
    h = r % m;
    if (k[31] && h != 0) h = m - h;
    return int'(h);
  endfunction

  // Apply one request to the shadow table and return the response it must give.
  function automatic rsp_t apply_request(req_t rq);
    rsp_t        rs;
    int unsigned m, pos, steps;
    logic        hit, hole, full;
    m = (size < 2) ? 2 : (size > TableDepth) ? TableDepth : size;
    pos = home_of(rq.key, m);
    steps = 0;
    hit = 0;
    hole = 0;
    full = 0;
    while (steps < m && !hit && !hole) begin
      if (slot_state[pos] == ST_EMPTY) hole = 1;
      else if (slot_state[pos] == ST_LIVE && slot_key[pos] == rq.key) hit = 1;
      else begin
        pos = (pos + 1 == m) ? 0 : pos + 1;
        steps++;
      end
    end
    if (rq.operation == OP_INSERT) begin
      if (!hit) begin
        if (!hole || live_cnt + tomb_cnt >= m / 2) full = 1;
        else begin
          slot_key[pos] = rq.key;
          slot_state[pos] = ST_LIVE;
          live_cnt++;
        end
      end
    end else if (rq.operation == OP_DELETE && hit) begin
      slot_state[pos] = ST_TOMB;
      live_cnt--;
      tomb_cnt++;
    end
    rs.found = hit;
    rs.table_full = full;
    rs.live_entries = live_cnt[10:0];
    return rs;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      mult = 10'd31;
      prime = 31'd1031;
      size = 11'd1024;
      foreach (slot_state[i]) slot_state[i] = ST_EMPTY;
      live_cnt = 0;
      tomb_cnt = 0;
      rsp_due.delete();
      fails = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MULT:  mult = cfg_data[9:0];
          CFG_PRIME: prime = cfg_data;
          CFG_SIZE:  size = cfg_data[10:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) rsp_due = {rsp_due, apply_request(in_data)};
      if (out_valid && out_ready) begin
        if (rsp_due.size() == 0) begin
          $error("response with nothing outstanding: %p", out_data);
          fails++;
        end else begin
          want = rsp_due.pop_front();
          if (out_data.found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, out_data.found);
            fails++;
          end
          if (out_data.table_full !== want.table_full) begin
            $error("table_full: expected %0d, got %0d", want.table_full,
                   out_data.table_full);
            fails++;
          end
          if (out_data.live_entries !== want.live_entries) begin
            $error("live_entries: expected %0d, got %0d", want.live_entries,
                   out_data.live_entries);
            fails++;
          end
        end
      end
    end
  end

endmodule

FILE: test/open_addressing_hash_set_core_tb.sv
// Testbench top for the hash set core: stimulus, stalls and the verdict.
module open_addressing_hash_set_core_tb;
  import ohs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int StallLimit = 20000; // covers the clearing pass and the longest walk

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_we = 0;
  logic [1:0]  cfg_index = CFG_MULT;
  logic [30:0] cfg_data = '0;
  logic        in_valid = 0;
  logic        in_ready;
  req_t        in_data = '0;
  logic        out_valid;
  logic        out_ready = 0;
  rsp_t        out_data;
  int          fails;
  int          pending;
  int          sent = 0;
  int          settings = 1;
  int          quiet_cycles = 0;
  logic        calm = 0;   // when set, neither side idles
  logic [31:0] key_pool [40];

  always #5 clk = ~clk;

  open_addressing_hash_set_core i_dut (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .in_data,
    .out_valid, .out_ready, .out_data
  );

  open_addressing_hash_set_core_chk i_chk (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .in_data,
    .out_valid, .out_ready, .out_data,
    .fails, .pending
  );

  // Watchdog: any long spell without a handshake ends the run.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("open_addressing_hash_set_core_tb: errors");
      $finish;
    end
  end

  // Response side: random back-pressure per response.
  initial begin
    int w;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      w = calm ? 0 : $urandom_range(0, 4);
      if (w > 0) begin
        out_ready <= 0;
        repeat (w) @(posedge clk);
      end
      out_ready <= 1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // One request: optional gap, then hold valid until taken.
  task automatic send(logic [1:0] op, logic [31:0] k);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_data.operation <= op;
    in_data.key <= k;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  // Drop valid and let every outstanding response drain.
  task automatic drain();
    in_valid <= 0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [30:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  task automatic set_hash(logic [9:0] m, logic [30:0] p, logic [10:0] s);
    write_reg(CFG_MULT, {21'd0, m});
    write_reg(CFG_PRIME, p);
    write_reg(CFG_SIZE, {20'd0, s});
    settings++;
  endtask

  // Random phase: mostly requests on a small key pool so hits and deletes land,
  // with some fully random keys as noise.
  task automatic random_phase(int count);
    logic [1:0]  op;
    logic [31:0] k;
    int          pick;
    foreach (key_pool[i])
      key_pool[i] = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 50) - 25 : $urandom;
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) calm = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      op = (pick < 45) ? OP_INSERT : (pick < 65) ? OP_DELETE :
           (pick < 95) ? OP_LOOKUP : OP_SPARE;
      k = ($urandom_range(0, 9) == 0) ? $urandom : key_pool[$urandom_range(0, 39)];
      send(op, k);
    end
    calm = 0;
    drain();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Small table, zero multiplier: every key lands on slot 0, fills at two.
    set_hash(10'd0, 31'h7FFF_FFFF, 11'd4);
    send(OP_INSERT, 32'd5);
    send(OP_INSERT, 32'd9);
    send(OP_INSERT, 32'd13);        // load limit refuses it
    send(OP_LOOKUP, 32'd5);
    drain();
    // Shrink below the built slots: walk covers the table without a hole.
    set_hash(10'd0, 31'h7FFF_FFFF, 11'd0);
    send(OP_LOOKUP, 32'd13);
    send(OP_INSERT, 32'd13);
    send(OP_DELETE, 32'd9);
    send(OP_LOOKUP, 32'd9);
    drain();
    // Oversized table setting acts as full depth; extreme keys.
    set_hash(10'd31, 31'd1031, 11'h7FF);
    send(OP_INSERT, 32'h8000_0000);
    send(OP_INSERT, 32'h7FFF_FFFF);
    send(OP_INSERT, 32'hFFFF_FFFF);
    send(OP_INSERT, 32'd0);
    send(OP_INSERT, 32'h8000_0000); // already present
    send(OP_LOOKUP, 32'h7FFF_FFFF);
    send(OP_DELETE, 32'hFFFF_FFFF);
    send(OP_DELETE, 32'hFFFF_FFFF); // already gone
    send(OP_LOOKUP, 32'hFFFF_FFFF);
    send(OP_SPARE, 32'd0);           // fourth code behaves as lookup
    send(OP_SPARE, 32'h1234_5678);
    send(OP_INSERT, 32'hFFFF_FFFF);  // tombstone is not reused
    drain();

    set_hash(10'h3FF, 31'd0, 11'd64);        // prime zero: all on slot 0
    random_phase(60);
    set_hash(10'd999, 31'd1, 11'd128);
    random_phase(80);
    set_hash(10'($urandom_range(0, 999)), 31'($urandom), 11'd300);
    random_phase(120);
    set_hash(10'd31, 31'd1031, 11'd1024);
    random_phase(150);
    set_hash(10'($urandom_range(0, 999)), 31'h7FFF_FFFF, 11'h7FF);
    random_phase(140);

    repeat (300) @(posedge clk);
    $display("Sent %0d requests over %0d hash settings, with random stalls on both sides.",
             sent, settings);
    if (fails == 0 && pending == 0) begin
      $display("open_addressing_hash_set_core_tb: clean");
    end else begin
      $display("open_addressing_hash_set_core_tb: errors");
    end
    $finish;
  end

endmodule

FILE: open_addressing_hash_set_core.f
design/ohs_pkg.sv
design/ohs_mod.sv
design/ohs_datapath.sv
design/ohs_ctrl.sv
design/open_addressing_hash_set_core.sv
test/open_addressing_hash_set_core_chk.sv
test/open_addressing_hash_set_core_tb.sv
